>>> hw/rtl/qte_pkg.sv
package qte_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN = 24;
	localparam int PROD_W = 32;
	localparam int SUM_W = 34;
	localparam int CW = 38;
	localparam int ZW = 28;
	localparam int SQ_W = 60;
	localparam int REM_W = 61;
	localparam int RT_W = 64;
	localparam int ROOT_W = 31;
	localparam int SQRT_ITERS = 32;
	localparam int ISQ_LAT = SQRT_ITERS + 1;
	localparam int FRONT_LAT = 3;
	localparam int POST_LAT = 2;

	localparam logic signed [SUM_W-1:0] ONE_Q30 = 34'sd1073741824;
	localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [ZW-1:0] PI_Q13 = 28'sd25736;
	localparam logic signed [ZW-1:0] HALF_PI_Q13 = 28'sd12868;
	localparam logic signed [23:0] RAD2DEG_Q16 = 24'sd3754936;
	localparam int YP_W = ZW + 24;
	localparam logic signed [YP_W-1:0] DEG_LIMIT_Q7 = 52'sd23040;

	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 28'sd13176795;
			1: v = 28'sd7778716;
			2: v = 28'sd4110060;
			3: v = 28'sd2086331;
			4: v = 28'sd1047214;
			5: v = 28'sd524117;
			6: v = 28'sd262123;
			7: v = 28'sd131069;
			8: v = 28'sd65536;
			9: v = 28'sd32768;
			10: v = 28'sd16384;
			11: v = 28'sd8192;
			12: v = 28'sd4096;
			13: v = 28'sd2048;
			14: v = 28'sd1024;
			15: v = 28'sd512;
			16: v = 28'sd256;
			17: v = 28'sd128;
			18: v = 28'sd64;
			19: v = 28'sd32;
			20: v = 28'sd16;
			21: v = 28'sd8;
			22: v = 28'sd4;
			23: v = 28'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [ZW-1:0] round_clamp_q13(input logic signed [ZW-1:0] z,
			input logic signed [ZW-1:0] lim);
		logic signed [ZW-1:0] r;
		r = (z + 28'sd1024) >>> 11;
		if (r > lim) r = lim;
		else if (r < -lim) r = -lim;
		return r;
	endfunction

endpackage

>>> hw/rtl/qte_front.sv
module qte_front import qte_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [15:0]      qx,
	input  logic signed [15:0]      qy,
	input  logic signed [15:0]      qz,
	input  logic signed [15:0]      qw,
	output logic signed [SUM_W-1:0] sinr,
	output logic signed [SUM_W-1:0] cosr,
	output logic signed [SUM_W-1:0] sinp,
	output logic signed [SUM_W-1:0] siny,
	output logic signed [SUM_W-1:0] cosy,
	output logic                    clamped,
	output logic [SQ_W-1:0]         sq
);

	logic signed [PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [SUM_W-1:0] sinr_s2, cosr_s2, sinp_s2, siny_s2, cosy_s2;
	logic signed [SUM_W-1:0] sinr_s3, cosr_s3, sinp_s3, siny_s3, cosy_s3;
	logic clamped_s3;
	logic [SQ_W-1:0] sq_s3;
	logic signed [SUM_W-1:0] sp_abs;
	logic [29:0] sp_mag;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sinr_s2 <= (SUM_W'(wx_s1) + SUM_W'(yz_s1)) <<< 1;
			cosr_s2 <= ONE_Q30 - ((SUM_W'(xx_s1) + SUM_W'(yy_s1)) <<< 1);
			sinp_s2 <= (SUM_W'(wy_s1) - SUM_W'(zx_s1)) <<< 1;
			siny_s2 <= (SUM_W'(wz_s1) + SUM_W'(xy_s1)) <<< 1;
			cosy_s2 <= ONE_Q30 - ((SUM_W'(yy_s1) + SUM_W'(zz_s1)) <<< 1);
		end
	end

	assign sp_abs = sinp_s2[SUM_W-1] ? -sinp_s2 : sinp_s2;
	assign sp_mag = sp_abs[29:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sinr_s3 <= sinr_s2;
			cosr_s3 <= cosr_s2;
			sinp_s3 <= sinp_s2;
			siny_s3 <= siny_s2;
			cosy_s3 <= cosy_s2;
			clamped_s3 <= (sinp_s2 >= ONE_Q30) || (sinp_s2 <= -ONE_Q30);
			sq_s3 <= sp_mag * sp_mag;
		end
	end

	assign sinr = sinr_s3;
	assign cosr = cosr_s3;
	assign sinp = sinp_s3;
	assign siny = siny_s3;
	assign cosy = cosy_s3;
	assign clamped = clamped_s3;
	assign sq = sq_s3;

endmodule

>>> hw/rtl/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; #(
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   sq,
	input  logic [SIDE_W-1:0] side_in,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);

	localparam logic [REM_W-1:0] ONE_Q60 = REM_W'(1) << 60;

	logic [REM_W-1:0]  n_s    [0:SQRT_ITERS];
	logic [RT_W-1:0]   r_s    [0:SQRT_ITERS];
	logic [SIDE_W-1:0] side_s [0:SQRT_ITERS];

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= ONE_Q60 - REM_W'(sq);
			r_s[0] <= '0;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < SQRT_ITERS; k++) begin : g_it
		localparam logic [RT_W-1:0] B = RT_W'(1) << (62 - 2 * k);
		logic [RT_W-1:0] rb;
		assign rb = r_s[k] + B;
		always_ff @(posedge clk) begin
			if (en) begin
				if (RT_W'(n_s[k]) >= rb) begin
					n_s[k+1] <= n_s[k] - rb[REM_W-1:0];
					r_s[k+1] <= (r_s[k] >> 1) + B;
				end else begin
					n_s[k+1] <= n_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign root = r_s[SQRT_ITERS][ROOT_W-1:0];
	assign side_out = side_s[SQRT_ITERS];

endmodule

>>> hw/rtl/qte_cordic.sv
module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [SUM_W-1:0] y_in,
	input  logic signed [SUM_W-1:0] x_in,
	output logic signed [ZW-1:0]    angle
);

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	logic                 zero_s [0:STEPS];
	logic signed [CW-1:0] xe, ye;

	assign xe = CW'(x_in);
	assign ye = CW'(y_in);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (!xe[CW-1]) begin
				x_s[0] <= xe;
				y_s[0] <= ye;
				z_s[0] <= '0;
			end else if (!ye[CW-1]) begin
				x_s[0] <= ye;
				y_s[0] <= -xe;
				z_s[0] <= HALF_PI_Q24;
			end else begin
				x_s[0] <= -ye;
				y_s[0] <= xe;
				z_s[0] <= -HALF_PI_Q24;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] ATAN = atan_q24(i);
		logic signed [CW-1:0] dx, dy;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + ATAN;
				end else begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - ATAN;
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	assign angle = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule

>>> hw/rtl/quaternion_to_euler_top.sv
// Quaternion to roll (radians, Q3.13), pitch (radians, Q2.13) and yaw (degrees, Q9.7). Fully
// pipelined: one quaternion is accepted every cycle unless stalled, and each result
// passes three stages of products, sums and pitch-sine square, a load stage and 32 stages of
// square root for the pitch cosine, one stage of quadrant pre-rotation and CORDIC_STEPS
// vectoring stages shared in form by all three angles, then two stages of rounding and
// degree scaling. The whole pipeline holds while a result is waiting and out_ready is low.
module quaternion_to_euler_top import qte_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic signed [15:0] qz,
	input  logic signed [15:0] qw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] roll_rad,
	output logic signed [14:0] pitch_rad,
	output logic signed [15:0] yaw_deg,
	output logic               pitch_clamped
);

	localparam int LAT = FRONT_LAT + ISQ_LAT + 1 + CORDIC_STEPS + POST_LAT;
	localparam int SIDE_W = 5 * SUM_W + 1;

	logic en;
	logic [LAT-1:0] v_q;

	logic signed [SUM_W-1:0] sinr, cosr, sinp, siny, cosy;
	logic clamped;
	logic [SQ_W-1:0] sq;
	logic [SIDE_W-1:0] side_in, side_out;
	logic [ROOT_W-1:0] root;
	logic signed [SUM_W-1:0] sinr_d, cosr_d, sinp_d, siny_d, cosy_d;
	logic clamped_d;
	logic signed [ZW-1:0] a_roll, a_pitch, a_yaw;

	logic [1:0] cl_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0] roll_s1, pitch_s1;
	logic signed [YP_W-1:0] yprod_s1;
	logic clamped_s1;
	logic signed [15:0] roll_s2, yaw_s2;
	logic signed [14:0] pitch_s2;
	logic clamped_s2;
	logic signed [YP_W-1:0] yr;
	logic signed [ZW-1:0] pitch_sel;

	assign en = !v_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = v_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	qte_front u_front (
		.clk(clk), .en(en), .qx(qx), .qy(qy), .qz(qz), .qw(qw),
		.sinr(sinr), .cosr(cosr), .sinp(sinp), .siny(siny), .cosy(cosy),
		.clamped(clamped), .sq(sq)
	);

	assign side_in = {sinr, cosr, sinp, siny, cosy, clamped};

	qte_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
		.clk(clk), .en(en), .sq(sq), .side_in(side_in),
		.root(root), .side_out(side_out)
	);

	assign {sinr_d, cosr_d, sinp_d, siny_d, cosy_d, clamped_d} = side_out;

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .y_in(sinr_d), .x_in(cosr_d), .angle(a_roll)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .y_in(sinp_d), .x_in(SUM_W'(root)), .angle(a_pitch)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(en), .y_in(siny_d), .x_in(cosy_d), .angle(a_yaw)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cl_s[0] <= {clamped_d, sinp_d > 0};
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cl
		always_ff @(posedge clk) begin
			if (en) begin
				cl_s[i+1] <= cl_s[i];
			end
		end
	end

	assign pitch_sel = cl_s[CORDIC_STEPS][0] ? HALF_PI_Q13 : -HALF_PI_Q13;

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s1 <= round_clamp_q13(a_roll, PI_Q13);
			pitch_s1 <= cl_s[CORDIC_STEPS][1] ? pitch_sel :
				round_clamp_q13(a_pitch, HALF_PI_Q13);
			clamped_s1 <= cl_s[CORDIC_STEPS][1];
			yprod_s1 <= YP_W'(a_yaw) * YP_W'(RAD2DEG_Q16);
		end
	end

	always_comb begin
		yr = (yprod_s1 + (YP_W'(1) <<< 32)) >>> 33;
		if (yr > DEG_LIMIT_Q7) yr = DEG_LIMIT_Q7;
		else if (yr < -DEG_LIMIT_Q7) yr = -DEG_LIMIT_Q7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s2 <= roll_s1[15:0];
			pitch_s2 <= pitch_s1[14:0];
			yaw_s2 <= yr[15:0];
			clamped_s2 <= clamped_s1;
		end
	end

	assign roll_rad = roll_s2;
	assign pitch_rad = pitch_s2;
	assign yaw_deg = yaw_s2;
	assign pitch_clamped = clamped_s2;

endmodule

>>> tb/sv/quaternion_to_euler_top_tb.sv
module quaternion_to_euler_top_tb;
	import qte_pkg::*;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               clamped;
		bit                 pitch_only;
	} angles_t;

	typedef struct {
		logic signed [15:0] x, y, z, w;
		bit                 typed;
		logic signed [14:0] pitch;
		logic               clamped;
	} quat_row_t;

	localparam longint ONE30 = 64'sd1073741824;
	localparam longint HALF_PI24 = 64'sd26353589;
	localparam longint DEG_SCALE = 64'sd3754936;
	localparam int LIMIT = 200000;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [15:0] qx = 0, qy = 0, qz = 0, qw = 0;
	logic signed [15:0] roll_rad, yaw_deg;
	logic signed [14:0] pitch_rad;
	logic pitch_clamped;

	angles_t angle_q[$];
	int errors = 0, cycles = 0, stall = 0;
	bit done = 0;

	longint atan_q24[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
		131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	quaternion_to_euler_top dut (.*);

	always #1 clk = ~clk;

	function automatic longint vec_angle(longint y, longint x);
		longint z, nx, ny, t;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI24;
			end else begin
				x = -y; y = t; z = -HALF_PI24;
			end
		end
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q24[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q24[i];
			end
			x = nx; y = ny;
		end
		return z;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0; b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b; r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint rnd_lim(longint v, int s, longint lim);
		longint r;
		r = (v + (64'sd1 << (s - 1))) >>> s;
		return r > lim ? lim : (r < -lim ? -lim : r);
	endfunction

	function automatic angles_t euler_of(quat_row_t q);
		longint x, y, z, w, sp;
		longint unsigned c;
		angles_t e;
		x = q.x; y = q.y; z = q.z; w = q.w;
		e.roll = 16'(rnd_lim(vec_angle(2 * (w * x + y * z), ONE30 - 2 * (x * x + y * y)), 11,
			25736));
		sp = 2 * (w * y - z * x);
		e.clamped = sp >= ONE30 || sp <= -ONE30;
		if (e.clamped)
			e.pitch = sp > 0 ? 15'sd12868 : -15'sd12868;
		else begin
			c = root_floor((64'd1 << 60) - longint'(sp * sp));
			e.pitch = 15'(rnd_lim(vec_angle(sp, longint'(c)), 11, 12868));
		end
		e.yaw = 16'(rnd_lim(vec_angle(2 * (w * z + x * y), ONE30 - 2 * (y * y + z * z)) *
			DEG_SCALE, 33, 23040));
		e.pitch_only = 0;
		if (q.typed) begin
			e.pitch = q.pitch; e.clamped = q.clamped; e.pitch_only = 1;
		end
		return e;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		angles_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (angle_q.size() == 0)
				report("unexpected request", 0, 0);
			else begin
				e = angle_q.pop_front();
				if (pitch_rad !== e.pitch) report("pitch_rad", pitch_rad, e.pitch);
				if (pitch_clamped !== e.clamped) report("pitch_clamped", pitch_clamped, e.clamped);
				if (!e.pitch_only) begin
					if (roll_rad !== e.roll) report("roll_rad", roll_rad, e.roll);
					if (yaw_deg !== e.yaw) report("yaw_deg", yaw_deg, e.yaw);
				end
			end
		end
	end

	always @(posedge clk) begin
		int s;
		s = stall;
		if (out_valid && out_ready && !done)
			s = $urandom_range(0, 6);
		if (done)
			s = 0;
		out_ready <= (s == 0);
		stall <= s > 0 ? s - 1 : 0;
	end

	task automatic send(quat_row_t q);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		qx <= q.x; qy <= q.y; qz <= q.z; qw <= q.w;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		angle_q.push_back(euler_of(q));
	endtask

	function automatic quat_row_t row(int x, int y, int z, int w,
			bit typed = 0, int p = 0, bit c = 0);
		quat_row_t q;
		q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.w = 16'(w);
		q.typed = typed; q.pitch = 15'(p); q.clamped = c;
		return q;
	endfunction

	quat_row_t directed[$];

	initial begin
		quat_row_t q;
		int k, n;
		directed = '{
			row(0, 0, 0, 0, 1, 0, 0),
			row(0, 0, 0, 32767),
			row(0, 0, 0, -32768),
			row(32767, 0, 0, 0),
			row(0, 32767, 0, 0),
			row(0, 0, 32767, 0),
			row(-32768, -32768, -32768, -32768, 1, 0, 0),
			row(32767, 32767, 32767, 32767, 1, 0, 0),
			row(0, -32768, 0, -32768, 1, 12868, 1),
			row(0, 32767, 0, -32768, 1, -12868, 1),
			row(-32768, 0, -32768, 0, 1, -12868, 1),
			row(0, 23170, 0, 23170),
			row(0, 23171, 0, 23171),
			row(23170, 0, 0, 23170),
			row(0, 0, 23170, 23170),
			row(0, 0, 23170, -23170),
			row(-23170, 0, 0, 23170),
			row(16384, 16384, 16384, 16384),
			row(32767, -32768, 32767, -32768),
			row(-1, -1, -1, -1),
			row(1, 0, 0, 0)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send(directed[i]);
		for (int i = 0; i < 550; i++) begin
			k = $urandom_range(0, 9);
			if (k < 5)
				q = row($urandom, $urandom, $urandom, $urandom);
			else if (k < 8) begin
				n = $urandom_range(0, 600);
				q = row(n - 300, 23170 + $urandom_range(0, 8) - 4, 300 - n,
					23170 + $urandom_range(0, 8) - 4);
				if ($urandom_range(0, 1)) begin
					q.y = -q.y; q.w = -q.w;
				end
				if ($urandom_range(0, 1)) q.w = -q.w;
			end else
				q = row($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
					$urandom_range(0, 32767) - 16384, $urandom_range(0, 65535) - 32768);
			send(q);
			if ($urandom_range(0, 60) == 0) begin
				in_valid <= 0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
		in_valid <= 0;
		done = 1;
		while (angle_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
